[sv/dkf_pkg.sv]
// ----------------------------------------------------------------------------
// dkf_pkg: shared types and constants of the diagonal Kalman filter core
// Register indexes, controller states, datapath commands and Q16.16 constants.
// ----------------------------------------------------------------------------
package dkf_pkg;

  localparam logic signed [31:0] QOne = 32'sd65536;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DivSteps = 48;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROCESS_NOISE      = 3'd0,
    REG_MEASUREMENT_NOISE  = 3'd1,
    REG_TRANSITION_GAIN    = 3'd2,
    REG_OBSERVATION_GAIN   = 3'd3,
    REG_INITIAL_COVARIANCE = 3'd4
  } reg_idx_e;

  // Multiplier operand selections and what the product feeds.
  typedef enum logic [3:0] {
    OP_XP,    // xp  = f * x
    OP_FP,    // t   = f * p
    OP_PP,    // pp  = t * f + q
    OP_HP,    // hp  = h * pp
    OP_S,     // s   = hp * h + r
    OP_DIV,   // k   = (hp << 16) / s
    OP_KH,    // kh  = k * h
    OP_PN,    // pn  = (1 - kh) * pp
    OP_HX,    // res = z - h * xp
    OP_XN,    // xn  = xp + k * res
    OP_NONE
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_XP, ST_FP, ST_PP, ST_HP, ST_S, ST_DIV, ST_DIVW,
    ST_KH, ST_PN, ST_HX, ST_XN, ST_OUT
  } ctl_state_e;

  typedef struct packed {
    logic   load;   // capture the accepted item
    dp_op_e op;     // arithmetic step to perform
    logic   commit; // write state back and fill output register
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic in_range;
  } dp_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

[sv/dkf_if.sv]
// ----------------------------------------------------------------------------
// dkf_if: valid/ready channels of the diagonal Kalman filter core
// Measurement input, result output and register write channels.
// ----------------------------------------------------------------------------
interface dkf_in_if;
  logic                valid;
  logic                ready;
  logic [3:0]          channel;
  logic signed [31:0]  measurement;
  modport source (output valid, channel, measurement, input ready);
  modport sink   (input valid, channel, measurement, output ready);
endinterface

interface dkf_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         out_channel;
  logic signed [31:0] estimate;
  logic signed [31:0] residual;
  logic signed [31:0] gain;
  logic               divide_fault;
  modport source (output valid, out_channel, estimate, residual, gain, divide_fault,
                  input ready);
  modport sink   (input valid, out_channel, estimate, residual, gain, divide_fault,
                  output ready);
endinterface

interface dkf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/dkf_ctrl.sv]
// ----------------------------------------------------------------------------
// dkf_ctrl: sequencer of the Kalman filter core
// Steps the datapath through predict, gain and update for one item.
// ----------------------------------------------------------------------------
module dkf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_busy_i,
  input  dkf_pkg::dp_sts_t sts_i,
  output dkf_pkg::dp_cmd_t cmd_o
);
  import dkf_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{load: 1'b0, op: OP_NONE, commit: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_XP;
        end
      end
      ST_XP: begin
        // An out-of-range channel skips all arithmetic.
        if (sts_i.in_range) begin
          cmd_o.op = OP_XP;
          state_d  = ST_FP;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_FP:  begin cmd_o.op = OP_FP;  state_d = ST_PP;   end
      ST_PP:  begin cmd_o.op = OP_PP;  state_d = ST_HP;   end
      ST_HP:  begin cmd_o.op = OP_HP;  state_d = ST_S;    end
      ST_S:   begin cmd_o.op = OP_S;   state_d = ST_DIV;  end
      ST_DIV: begin cmd_o.op = OP_DIV; state_d = ST_DIVW; end
      ST_DIVW: begin
        if (sts_i.div_done) state_d = ST_KH;
      end
      ST_KH:  begin cmd_o.op = OP_KH;  state_d = ST_PN;   end
      ST_PN:  begin cmd_o.op = OP_PN;  state_d = ST_HX;   end
      ST_HX:  begin cmd_o.op = OP_HX;  state_d = ST_XN;   end
      ST_XN:  begin cmd_o.op = OP_XN;  state_d = ST_OUT;  end
      ST_OUT: begin
        if (!out_busy_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[sv/dkf_datapath.sv]
// ----------------------------------------------------------------------------
// dkf_datapath: arithmetic and channel state of the Kalman filter core
// One shared rounding multiplier, a restoring divider and the channel arrays.
// ----------------------------------------------------------------------------
module dkf_datapath #(
  parameter int unsigned CHANNELS = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dkf_pkg::dp_cmd_t   cmd_i,
  output dkf_pkg::dp_sts_t   sts_o,
  input  logic [3:0]         in_channel_i,
  input  logic signed [31:0] in_measurement_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [3:0]         out_channel_o,
  output logic signed [31:0] out_estimate_o,
  output logic signed [31:0] out_residual_o,
  output logic signed [31:0] out_gain_o,
  output logic               out_fault_o
);
  import dkf_pkg::*;

  localparam int unsigned ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [30:0]        q_q, r_q, p0_q;
  logic signed [31:0] f_q, h_q;
  logic signed [31:0] est_q [CHANNELS];
  logic signed [31:0] cov_q [CHANNELS];

  logic [3:0]         ch_q;
  logic signed [31:0] z_q, xp_q, t_q, pp_q, hp_q, s_q, k_q, kh_q, pn_q, res_q, xn_q;
  logic               fault_q, in_range;
  logic [ChW-1:0]     idx;

  assign in_range = {28'd0, ch_q} < 32'(CHANNELS);
  assign idx      = ch_q[ChW-1:0];

  // Shared multiplier: Q16.16 product rounded half up, saturated.
  logic signed [31:0] ma, mb, prod_r;
  logic signed [63:0] prod;
  assign prod   = ma * mb;
  assign prod_r = sat32(66'((prod + 64'sd32768) >>> 16));

  always_comb begin
    ma = f_q;
    mb = f_q;
    case (cmd_i.op)
      OP_XP: begin ma = f_q;  mb = in_range ? est_q[idx] : '0; end
      OP_FP: begin ma = f_q;  mb = in_range ? cov_q[idx] : '0; end
      OP_PP: begin ma = t_q;  mb = f_q;  end
      OP_HP: begin ma = h_q;  mb = pp_q; end
      OP_S:  begin ma = hp_q; mb = h_q;  end
      OP_KH: begin ma = k_q;  mb = h_q;  end
      OP_PN: begin ma = sat32(66'sd65536 - 66'(kh_q)); mb = pp_q; end
      OP_HX: begin ma = h_q;  mb = xp_q; end
      OP_XN: begin ma = k_q;  mb = res_q; end
      default: ;
    endcase
  end

  // Restoring divider on magnitudes, one quotient bit per cycle.
  logic [47:0] dnum_q, dquo_q;
  logic [32:0] drem_q;
  logic [31:0] dden_q;
  logic        dneg_q, dbusy_q;
  logic [5:0]  dcnt_q;
  logic [32:0] dtry;
  logic [47:0] hp_ext;
  logic signed [49:0] qsigned;
  assign dtry   = {drem_q[31:0], dnum_q[47]};
  assign hp_ext = {hp_q, 16'd0};
  assign qsigned = dneg_q ? -$signed({2'b00, dquo_q}) : $signed({2'b00, dquo_q});
  assign sts_o  = '{div_done: !dbusy_q, in_range: in_range};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.op == OP_DIV && s_q != 0) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= 6'(DivSteps);
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q - 6'd1;
      if (dcnt_q == 6'd1) dbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_DIV) begin
      dnum_q <= hp_q[31] ? 48'(-$signed(hp_ext)) : hp_ext;
      dden_q <= s_q[31] ? 32'(-s_q) : 32'(s_q);
      dneg_q <= hp_q[31] ^ s_q[31];
      drem_q <= '0;
      dquo_q <= '0;
    end else if (dbusy_q) begin
      dnum_q <= {dnum_q[46:0], 1'b0};
      if (dtry >= {1'b0, dden_q}) begin
        drem_q <= dtry - {1'b0, dden_q};
        dquo_q <= {dquo_q[46:0], 1'b1};
      end else begin
        drem_q <= dtry;
        dquo_q <= {dquo_q[46:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q <= in_channel_i;
      z_q  <= in_measurement_i;
    end
    case (cmd_i.op)
      OP_XP: xp_q <= prod_r;
      OP_FP: t_q  <= prod_r;
      OP_PP: pp_q <= sat32(66'(prod_r) + 66'({1'b0, q_q}));
      OP_HP: hp_q <= prod_r;
      OP_S:  s_q  <= sat32(66'(prod_r) + 66'({1'b0, r_q}));
      OP_DIV: begin
        fault_q <= (s_q == 0);
        k_q     <= '0;
      end
      OP_KH: kh_q <= prod_r;
      OP_PN: pn_q <= prod_r[31] ? '0 : prod_r;
      OP_HX: res_q <= sat32(66'(z_q) - 66'(prod_r));
      OP_XN: xn_q <= sat32(66'(xp_q) + 66'(prod_r));
      default: ;
    endcase
    if (dbusy_q && dcnt_q == 6'd1) begin
      // Final bit lands this edge; saturate the signed quotient.
      k_q <= sat32(66'(dneg_q ? -$signed({2'b00, dquo_q[46:0], dtry >= {1'b0, dden_q}})
                               : $signed({2'b00, dquo_q[46:0], dtry >= {1'b0, dden_q}})));
    end
  end

  // Configuration and channel state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q  <= 31'd655;
      r_q  <= 31'd65536;
      f_q  <= QOne;
      h_q  <= QOne;
      p0_q <= 31'd6554;
      for (int i = 0; i < CHANNELS; i++) begin
        est_q[i] <= '0;
        cov_q[i] <= 32'sd6554;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_PROCESS_NOISE:     q_q <= cfg_data_i[30:0];
          REG_MEASUREMENT_NOISE: r_q <= cfg_data_i[30:0];
          REG_TRANSITION_GAIN:   f_q <= cfg_data_i;
          REG_OBSERVATION_GAIN:  h_q <= cfg_data_i;
          REG_INITIAL_COVARIANCE: begin
            p0_q <= cfg_data_i[30:0];
            for (int i = 0; i < CHANNELS; i++) cov_q[i] <= {1'b0, cfg_data_i[30:0]};
          end
          default: ;
        endcase
      end
      if (cmd_i.commit && in_range) begin
        est_q[idx] <= xn_q;
        cov_q[idx] <= fault_q ? pp_q : pn_q;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_channel_o  <= ch_q;
      out_estimate_o <= in_range ? xn_q : '0;
      out_residual_o <= in_range ? res_q : '0;
      out_gain_o     <= in_range ? k_q : '0;
      out_fault_o    <= in_range & fault_q;
    end
  end

  logic unused;
  assign unused = ^{qsigned, p0_q};

endmodule

[sv/diagonal_kalman_filter_core.sv]
// ----------------------------------------------------------------------------
// diagonal_kalman_filter_core: per-channel scalar Kalman filter, Q16.16
//
//   channel   dir  payload
//   in_ch     in   channel, measurement
//   out_ch    out  out_channel, estimate, residual, gain, divide_fault
//   cfg_ch    in   index, data (register write)
//
// An item passes through nine multiply steps on one shared multiplier, a divider
// launch and a 48-step restoring divider for the gain; the input is not ready
// again until the result has been committed to the output register.
// An out-of-range channel skips the arithmetic and goes straight to output.
// Reset loads the register defaults and the channel state at once.
// A full output register stalls the sequencer before commit.
// ----------------------------------------------------------------------------
module diagonal_kalman_filter_core #(
  parameter int unsigned CHANNELS = 3
) (
  input logic  clk_i,
  input logic  rst_ni,
  dkf_in_if.sink    in_ch,
  dkf_out_if.source out_ch,
  dkf_cfg_if.sink   cfg_ch
);
  import dkf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  dkf_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .out_busy_i (out_ch.valid & ~out_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dkf_datapath #(.CHANNELS(CHANNELS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_channel_i     (in_ch.channel),
    .in_measurement_i (in_ch.measurement),
    .cfg_we_i         (cfg_ch.valid),
    .cfg_index_i      (cfg_ch.index),
    .cfg_data_i       (cfg_ch.data),
    .out_ready_i      (out_ch.ready),
    .out_valid_o      (out_ch.valid),
    .out_channel_o    (out_ch.out_channel),
    .out_estimate_o   (out_ch.estimate),
    .out_residual_o   (out_ch.residual),
    .out_gain_o       (out_ch.gain),
    .out_fault_o      (out_ch.divide_fault)
  );

`ifndef ASSERT_OFF
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !(out_ch.valid && !out_ch.ready))
    else $error("commit into a held output register");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op != OP_NONE |-> !in_ch.ready)
    else $error("input ready while computing");
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_ch.valid)
    else $error("commit did not raise output valid");
`endif

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench of the diagonal Kalman filter core
// Drives measurements with random gaps and register writes, predicts every
// result with a bit-exact Q16.16 model of the filter and compares each one.
// ----------------------------------------------------------------------------
module tb;
  import dkf_pkg::*;

  localparam int unsigned NumCh = 3;

  typedef struct packed {
    logic [3:0]         chan;
    logic signed [31:0] est;
    logic signed [31:0] res;
    logic signed [31:0] k;
    logic               fault;
  } kf_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dkf_in_if  in_ch();
  dkf_out_if out_ch();
  dkf_cfg_if cfg_ch();

  diagonal_kalman_filter_core #(.CHANNELS(NumCh)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state and registers.
  logic [30:0]        m_q, m_r, m_p0;
  logic signed [31:0] m_f, m_h;
  logic signed [31:0] m_x [NumCh];
  logic signed [31:0] m_p [NumCh];

  kf_result_t expected_results[$];
  int  n_errors = 0;
  bit  hold_off = 1'b0;
  bit  random_gaps = 1'b1;

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Rounded Q16.16 product; >>> on a signed value is a floor shift.
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [65:0] prod;
    prod = 66'(a) * 66'(b) + 66'sd32768;
    return clamp32(prod >>> 16);
  endfunction

  function automatic kf_result_t filter_step(input logic [3:0] ch,
                                             input logic signed [31:0] z);
    kf_result_t r;
    logic signed [31:0] xp, pp, hp, s, k, kh, pn, hx, rs, xn;
    logic signed [65:0] num;
    r = '0;
    r.chan = ch;
    if (ch >= NumCh) return r;
    xp = fx_mul(m_f, m_x[ch]);
    pp = clamp32(66'(fx_mul(fx_mul(m_f, m_p[ch]), m_f)) + 66'($signed({1'b0, m_q})));
    hp = fx_mul(m_h, pp);
    s  = clamp32(66'(fx_mul(hp, m_h)) + 66'($signed({1'b0, m_r})));
    if (s == 0) begin
      k = 0;
      r.fault = 1'b1;
    end else begin
      num = 66'(hp) * 66'sd65536;
      k = clamp32(num / 66'(s));
    end
    kh = fx_mul(k, m_h);
    pn = fx_mul(clamp32(66'sd65536 - 66'(kh)), pp);
    if (pn < 0) pn = 0;
    hx = fx_mul(m_h, xp);
    rs = clamp32(66'(z) - 66'(hx));
    xn = clamp32(66'(xp) + 66'(fx_mul(k, rs)));
    m_x[ch] = xn;
    m_p[ch] = pn;
    r.est = xn; r.res = rs; r.k = k;
    return r;
  endfunction

  task automatic model_reset();
    m_q = 655; m_r = 65536; m_f = 65536; m_h = 65536; m_p0 = 6554;
    for (int i = 0; i < NumCh; i++) begin
      m_x[i] = 0;
      m_p[i] = 6554;
    end
  endtask

  function automatic int gap_len();
    int g;
    g = 0;
    if (!random_gaps) return 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: g = 0;
      5, 6, 7: g = $urandom_range(1, 3);
      8: g = $urandom_range(4, 12);
      default: g = $urandom_range(20, 90);
    endcase
    return g;
  endfunction

  // Valid stays high after an accepted item until the next gap or drain, so
  // that back-to-back items never assign it twice in one time step.
  task automatic send_item(input logic [3:0] ch, input logic signed [31:0] z);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.channel <= ch;
    in_ch.measurement <= z;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_results.push_back(filter_step(ch, z));
  endtask

  // Waits until every expected item has arrived and the core is quiet.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] data);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_PROCESS_NOISE:      m_q = data[30:0];
      REG_MEASUREMENT_NOISE:  m_r = data[30:0];
      REG_TRANSITION_GAIN:    m_f = data;
      REG_OBSERVATION_GAIN:   m_h = data;
      REG_INITIAL_COVARIANCE: begin
        m_p0 = data[30:0];
        for (int i = 0; i < NumCh; i++) m_p[i] = $signed({1'b0, m_p0});
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] rand_meas();
    logic signed [31:0] v;
    v = 0;
    case ($urandom_range(0, 7))
      0: v = 32'sh7fffffff;
      1: v = 32'sh80000000;
      2: v = $urandom();
      default: v = $signed($urandom_range(0, 20 << 16)) - (10 << 16);
    endcase
    return v;
  endfunction

  // Result checker and output back-pressure.
  always @(posedge clk_i) begin
    kf_result_t e;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no item pending: channel %0d", out_ch.out_channel);
        n_errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_ch.out_channel !== e.chan) begin
          $error("out_channel exp %0d got %0d", e.chan, out_ch.out_channel);
          n_errors++;
        end
        if (out_ch.estimate !== e.est) begin
          $error("estimate exp %0d got %0d", e.est, out_ch.estimate);
          n_errors++;
        end
        if (out_ch.residual !== e.res) begin
          $error("residual exp %0d got %0d", e.res, out_ch.residual);
          n_errors++;
        end
        if (out_ch.gain !== e.k) begin
          $error("gain exp %0d got %0d", e.k, out_ch.gain);
          n_errors++;
        end
        if (out_ch.divide_fault !== e.fault) begin
          $error("divide_fault exp %0d got %0d", e.fault, out_ch.divide_fault);
          n_errors++;
        end
      end
    end
    if (hold_off) out_ch.ready <= 1'b0;
    else if (!random_gaps) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 9) < 7);
  end

  // Long receiver stall counted in its own process.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (1500) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        random_gaps = 1'b0;
        for (int i = 0; i < 12; i++) send_item(4'(i % NumCh), rand_meas());
        random_gaps = 1'b1;
      end
    join
  endtask

  task automatic test_directed();
    send_item(0, 32'sh7fffffff);
    send_item(1, 32'sh80000000);
    send_item(2, 0);
    send_item(0, 65536);
    send_item(4'd3, 12345);
    send_item(4'd15, -1);
    send_item(1, -65536);
    // Zero divisor: r = 0 and h = 0 give s = 0.
    write_reg(REG_MEASUREMENT_NOISE, 0);
    write_reg(REG_OBSERVATION_GAIN, 0);
    send_item(0, 5 << 16);
    send_item(2, -3);
    write_reg(REG_OBSERVATION_GAIN, 32'h80000000);
    write_reg(REG_MEASUREMENT_NOISE, 32'hffffffff);
    write_reg(REG_PROCESS_NOISE, 32'h7fffffff);
    write_reg(REG_TRANSITION_GAIN, 32'h7fffffff);
    send_item(0, 32'sh7fffffff);
    send_item(1, 1);
    write_reg(REG_TRANSITION_GAIN, 32'h80000000);
    write_reg(REG_PROCESS_NOISE, 0);
    write_reg(REG_INITIAL_COVARIANCE, 32'hffffffff);
    send_item(2, 32'sh80000000);
    send_item(1, 100);
    write_reg(REG_INITIAL_COVARIANCE, 0);
    send_item(0, 7);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_PROCESS_NOISE, 655);
          write_reg(REG_MEASUREMENT_NOISE, 65536);
          write_reg(REG_TRANSITION_GAIN, 65536);
          write_reg(REG_OBSERVATION_GAIN, 65536);
          write_reg(REG_INITIAL_COVARIANCE, 6554);
        end
        1, 2, 3: begin
          write_reg(REG_PROCESS_NOISE, $urandom_range(0, 1 << 18));
          write_reg(REG_MEASUREMENT_NOISE, $urandom_range(0, 1 << 18));
          write_reg(REG_TRANSITION_GAIN, $urandom_range(0, 1 << 17) - (1 << 16));
          write_reg(REG_OBSERVATION_GAIN, $urandom_range(0, 1 << 18) - (1 << 17));
          write_reg(REG_INITIAL_COVARIANCE, $urandom_range(0, 1 << 18));
        end
        default: begin
          write_reg(REG_PROCESS_NOISE, $urandom());
          write_reg(REG_MEASUREMENT_NOISE, $urandom());
          write_reg(REG_TRANSITION_GAIN, $urandom());
          write_reg(REG_OBSERVATION_GAIN, $urandom());
          write_reg(REG_INITIAL_COVARIANCE, $urandom());
        end
      endcase
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(0, 19) == 0) send_item(4'($urandom_range(NumCh, 15)), rand_meas());
        else send_item(4'($urandom_range(0, NumCh - 1)), rand_meas());
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.channel = '0;
    in_ch.measurement = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_PROCESS_NOISE;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    model_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    drain();
    if (n_errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end
endmodule

[diagonal_kalman_filter_core.f]
sv/dkf_pkg.sv
sv/dkf_if.sv
sv/dkf_ctrl.sv
sv/dkf_datapath.sv
sv/diagonal_kalman_filter_core.sv
tb/tb.sv
